// File: design/decimal_to_roman_symbols_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal to Roman symbols unit
// Each check is compiled in for simulation and left empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TO_ROMAN_SYMBOLS_UNIT_DEFINES_SVH
`define DECIMAL_TO_ROMAN_SYMBOLS_UNIT_DEFINES_SVH

`ifndef SYNTH

// Property that must hold in the same cycle
`define DRSU_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("drsu check failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define DRSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drsu check failed");

`else

`define DRSU_ASSERT_NOW(label, cond)
`define DRSU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: design/drsu_pkg.sv
// ----------------------------------------------------------------------------
// drsu_pkg
// Shared types, constants and the greedy step table of the Roman symbol unit.
// ----------------------------------------------------------------------------
package drsu_pkg;

  // Field widths
  localparam int VALUE_W  = 22;
  localparam int AMOUNT_W = 20;
  localparam int SYM_W    = 3;
  localparam int NUM_STEPS = 25;
  localparam int STEP_W   = $clog2(NUM_STEPS);

  // Largest value that has a numeral
  localparam logic [VALUE_W-1:0] MAX_VALUE = 22'd3999999;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Letter codes
  localparam logic [SYM_W-1:0] SYM_I = 3'd0;
  localparam logic [SYM_W-1:0] SYM_V = 3'd1;
  localparam logic [SYM_W-1:0] SYM_X = 3'd2;
  localparam logic [SYM_W-1:0] SYM_L = 3'd3;
  localparam logic [SYM_W-1:0] SYM_C = 3'd4;
  localparam logic [SYM_W-1:0] SYM_D = 3'd5;
  localparam logic [SYM_W-1:0] SYM_M = 3'd6;

  // Class of an accepted value
  typedef enum logic [1:0] {
    KIND_NUMERAL,
    KIND_ZERO,
    KIND_RANGE
  } kind_t;

  // Queue entry
  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // Queue head seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // Front end status
  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } front_status_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_PAIR
  } back_state_t;

  // One greedy step: amount, one or two symbols, repeat allowed
  typedef struct packed {
    logic [AMOUNT_W-1:0] amount;
    logic                pair;
    logic [SYM_W-1:0]    sym0;
    logic                ov0;
    logic [SYM_W-1:0]    sym1;
    logic                ov1;
    logic                repeat_ok;
  } step_t;

  function automatic step_t step_table(input logic [STEP_W-1:0] idx);
    step_t s;
    case (idx)
      5'd0:  s = '{20'd1000000, 1'b0, SYM_M, 1'b1, SYM_I, 1'b0, 1'b1};
      5'd1:  s = '{20'd900000,  1'b1, SYM_C, 1'b1, SYM_M, 1'b1, 1'b0};
      5'd2:  s = '{20'd500000,  1'b0, SYM_D, 1'b1, SYM_I, 1'b0, 1'b0};
      5'd3:  s = '{20'd400000,  1'b1, SYM_C, 1'b1, SYM_D, 1'b1, 1'b0};
      5'd4:  s = '{20'd100000,  1'b0, SYM_C, 1'b1, SYM_I, 1'b0, 1'b1};
      5'd5:  s = '{20'd90000,   1'b1, SYM_X, 1'b1, SYM_C, 1'b1, 1'b0};
      5'd6:  s = '{20'd50000,   1'b0, SYM_L, 1'b1, SYM_I, 1'b0, 1'b0};
      5'd7:  s = '{20'd40000,   1'b1, SYM_X, 1'b1, SYM_L, 1'b1, 1'b0};
      5'd8:  s = '{20'd10000,   1'b0, SYM_X, 1'b1, SYM_I, 1'b0, 1'b1};
      5'd9:  s = '{20'd9000,    1'b1, SYM_M, 1'b0, SYM_X, 1'b1, 1'b0};
      5'd10: s = '{20'd5000,    1'b0, SYM_V, 1'b1, SYM_I, 1'b0, 1'b0};
      5'd11: s = '{20'd4000,    1'b1, SYM_M, 1'b0, SYM_V, 1'b1, 1'b0};
      5'd12: s = '{20'd1000,    1'b0, SYM_M, 1'b0, SYM_I, 1'b0, 1'b1};
      5'd13: s = '{20'd900,     1'b1, SYM_C, 1'b0, SYM_M, 1'b0, 1'b0};
      5'd14: s = '{20'd500,     1'b0, SYM_D, 1'b0, SYM_I, 1'b0, 1'b0};
      5'd15: s = '{20'd400,     1'b1, SYM_C, 1'b0, SYM_D, 1'b0, 1'b0};
      5'd16: s = '{20'd100,     1'b0, SYM_C, 1'b0, SYM_I, 1'b0, 1'b1};
      5'd17: s = '{20'd90,      1'b1, SYM_X, 1'b0, SYM_C, 1'b0, 1'b0};
      5'd18: s = '{20'd50,      1'b0, SYM_L, 1'b0, SYM_I, 1'b0, 1'b0};
      5'd19: s = '{20'd40,      1'b1, SYM_X, 1'b0, SYM_L, 1'b0, 1'b0};
      5'd20: s = '{20'd10,      1'b0, SYM_X, 1'b0, SYM_I, 1'b0, 1'b1};
      5'd21: s = '{20'd9,       1'b1, SYM_I, 1'b0, SYM_X, 1'b0, 1'b0};
      5'd22: s = '{20'd5,       1'b0, SYM_V, 1'b0, SYM_I, 1'b0, 1'b0};
      5'd23: s = '{20'd4,       1'b1, SYM_I, 1'b0, SYM_V, 1'b0, 1'b0};
      // ones step, also for unused indexes
      default: s = '{20'd1,     1'b0, SYM_I, 1'b0, SYM_I, 1'b0, 1'b1};
    endcase
    return s;
  endfunction

endpackage

// File: design/drsu_front.sv
// ----------------------------------------------------------------------------
// drsu_front
// Accepts input values, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module drsu_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [drsu_pkg::VALUE_W-1:0]      in_value,
  output drsu_pkg::head_t                   head,
  input  logic                              pop,
  output drsu_pkg::front_status_t           status
);

  drsu_pkg::entry_t                  mem [drsu_pkg::QUEUE_DEPTH];
  logic [drsu_pkg::QPTR_W-1:0]       wr_ptr;
  logic [drsu_pkg::QPTR_W-1:0]       rd_ptr;
  logic [drsu_pkg::QCNT_W-1:0]       count;
  logic                              push;
  logic                              do_pop;
  drsu_pkg::entry_t                  new_entry;

  // Classify the incoming value
  always_comb begin
    new_entry.value = in_value;
    if (in_value > drsu_pkg::MAX_VALUE) begin
      new_entry.kind = drsu_pkg::KIND_RANGE;
    end else if (in_value == '0) begin
      new_entry.kind = drsu_pkg::KIND_ZERO;
    end else begin
      new_entry.kind = drsu_pkg::KIND_NUMERAL;
    end
  end

  assign s_tready = (count != drsu_pkg::QCNT_W'(drsu_pkg::QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign do_pop   = pop && (count != '0);

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= new_entry;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid    = (count != '0);
  assign head.entry    = mem[rd_ptr];
  assign status.count  = count;

endmodule

// File: design/drsu_back.sv
// ----------------------------------------------------------------------------
// drsu_back
// Greedy sequencer: walks the step table; finishes one value before the next.
// ----------------------------------------------------------------------------
module drsu_back (
  input  logic                           clk,
  input  logic                           rst,
  input  drsu_pkg::head_t                head,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [drsu_pkg::SYM_W-1:0]     out_symbol,
  output logic                           out_overline,
  output logic                           out_present,
  output logic                           out_range_error,
  output logic                           out_last
);

  drsu_pkg::back_state_t             state;
  drsu_pkg::back_state_t             state_next;
  logic [drsu_pkg::VALUE_W-1:0]      remaining;
  logic [drsu_pkg::STEP_W-1:0]       place_step;
  drsu_pkg::step_t                   cur;
  logic [drsu_pkg::VALUE_W-1:0]      amount_ext;
  logic [drsu_pkg::VALUE_W-1:0]      diff;
  logic                              ge;
  logic                              slot_free;
  logic                              load;
  logic                              sub_en;
  logic                              step_inc;
  logic                              emit;
  logic [drsu_pkg::SYM_W-1:0]        emit_sym;
  logic                              emit_ov;
  logic                              emit_present;
  logic                              emit_err;
  logic                              emit_last;

  // Current step and the compare/subtract against it
  assign cur        = drsu_pkg::step_table(place_step);
  assign amount_ext = drsu_pkg::VALUE_W'(cur.amount);
  assign ge         = (remaining >= amount_ext);
  assign diff       = remaining - amount_ext;
  assign slot_free  = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      drsu_pkg::BK_IDLE: begin
        if (head.valid && slot_free &&
            head.entry.kind == drsu_pkg::KIND_NUMERAL) begin
          state_next = drsu_pkg::BK_RUN;
        end
      end
      drsu_pkg::BK_RUN: begin
        if (slot_free && ge) begin
          if (cur.pair) begin
            state_next = drsu_pkg::BK_PAIR;
          end else if (diff == '0) begin
            state_next = drsu_pkg::BK_IDLE;
          end
        end
      end
      drsu_pkg::BK_PAIR: begin
        if (slot_free) begin
          state_next = (diff == '0) ? drsu_pkg::BK_IDLE : drsu_pkg::BK_RUN;
        end
      end
      default: state_next = drsu_pkg::BK_IDLE;
    endcase
  end

  // Datapath controls and the symbol to emit
  always_comb begin
    pop          = 1'b0;
    load         = 1'b0;
    sub_en       = 1'b0;
    step_inc     = 1'b0;
    emit         = 1'b0;
    emit_sym     = drsu_pkg::SYM_I;
    emit_ov      = 1'b0;
    emit_present = 1'b0;
    emit_err     = 1'b0;
    emit_last    = 1'b0;
    case (state)
      drsu_pkg::BK_IDLE: begin
        if (head.valid && slot_free) begin
          pop = 1'b1;
          if (head.entry.kind == drsu_pkg::KIND_NUMERAL) begin
            load = 1'b1;
          end else begin
            emit      = 1'b1;
            emit_err  = (head.entry.kind == drsu_pkg::KIND_RANGE);
            emit_last = 1'b1;
          end
        end
      end
      drsu_pkg::BK_RUN: begin
        if (slot_free) begin
          if (ge) begin
            emit         = 1'b1;
            emit_sym     = cur.sym0;
            emit_ov      = cur.ov0;
            emit_present = 1'b1;
            if (!cur.pair) begin
              sub_en    = 1'b1;
              step_inc  = !cur.repeat_ok;
              emit_last = (diff == '0);
            end
          end else begin
            step_inc = 1'b1;
          end
        end
      end
      drsu_pkg::BK_PAIR: begin
        if (slot_free) begin
          emit         = 1'b1;
          emit_sym     = cur.sym1;
          emit_ov      = cur.ov1;
          emit_present = 1'b1;
          sub_en       = 1'b1;
          step_inc     = 1'b1;
          emit_last    = (diff == '0);
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= drsu_pkg::BK_IDLE;
      remaining  <= '0;
      place_step <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        remaining  <= head.entry.value;
        place_step <= '0;
      end else begin
        if (sub_en) begin
          remaining <= diff;
        end
        if (step_inc) begin
          place_step <= place_step + 1'b1;
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_symbol      <= emit_sym;
      out_overline    <= emit_ov;
      out_present     <= emit_present;
      out_range_error <= emit_err;
      out_last        <= emit_last;
    end
  end

endmodule

// File: design/decimal_to_roman_symbols_unit.sv
// ----------------------------------------------------------------------------
// decimal_to_roman_symbols_unit
// Converts a binary value (0..3999999) into a stream of Roman numeral symbols.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one value per transaction in s_tdata[21:0].
//   Master channel m_* carries one symbol per transaction; m_tlast marks the
//   final symbol of a value. Zero gives one transaction with present low;
//   a value above 3999999 gives one transaction with range_error high.
// Path: an accepted value goes into the queue, then into the sequencer's
//   remaining register; each symbol leaves through the output register.
// Conversion: the greedy walk steps through the table (25 steps), emitting
//   symbols and passing steps that give none; zero and out-of-range values
//   give their single transaction without a walk. The greedy sequencer, one
//   step compare and subtract per cycle while not stalled, sets the pace.
// A two-entry queue lets values be taken while a conversion runs.
// Reset: queue empty, sequencer idle, no output transaction pending.
// Stall: while m_tready is low the output register holds; the sequencer
//   waits, and s_tready drops once the queue is full.
// ----------------------------------------------------------------------------
`include "decimal_to_roman_symbols_unit_defines.svh"

module decimal_to_roman_symbols_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [21:0] value, [23:22] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [2:0] symbol, [3] overline, [7:4] zero
  output logic [1:0]  m_tuser,   // [0] present, [1] range_error
  output logic        m_tlast
);

  drsu_pkg::head_t                 head;
  drsu_pkg::front_status_t         front_status;
  logic                            pop;
  logic [drsu_pkg::SYM_W-1:0]      out_symbol;
  logic                            out_overline;
  logic                            out_present;
  logic                            out_range_error;
  logic                            out_last;

  // Front end: accept and classify
  drsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_value (s_tdata[drsu_pkg::VALUE_W-1:0]),
    .head     (head),
    .pop      (pop),
    .status   (front_status)
  );

  // Back end: greedy symbol sequencer
  drsu_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .out_symbol      (out_symbol),
    .out_overline    (out_overline),
    .out_present     (out_present),
    .out_range_error (out_range_error),
    .out_last        (out_last)
  );

  // Output packing
  assign m_tdata = {4'b0000, out_overline, out_symbol};
  assign m_tuser = {out_range_error, out_present};
  assign m_tlast = out_last;

  // Checks
  `DRSU_ASSERT_NOW(a_queue_bound, front_status.count <= drsu_pkg::QCNT_W'(drsu_pkg::QUEUE_DEPTH))
  `DRSU_ASSERT_NOW(a_error_alone, !(m_tvalid && m_tuser[1]) || (!m_tuser[0] && m_tlast))
  `DRSU_ASSERT_NOW(a_symbol_code, !(m_tvalid && m_tuser[0]) || (m_tdata[2:0] != 3'd7))
  `DRSU_ASSERT_NOW(a_pop_has_head, !pop || (front_status.count != '0))
  `DRSU_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))

endmodule
